// ===== hw/rtl/tlvfc_pkg.sv =====
// Shared types, register indexes, status codes and checksum helper of the TLV frame checker.
`default_nettype none

package tlvfc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_SIZE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_CLASS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRIM_TYPE_MIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRIM_TYPE_MAX = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMP_TYPE_MIN = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMP_TYPE_MAX = 3'd5;

    // Frame status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    // Result kinds carried on tuser.
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [16:0] check_size;    // two's complement
        logic [1:0]  frame_class;
        logic [4:0]  prim_type_min;
        logic [4:0]  prim_type_max;
        logic [4:0]  comp_type_min;
        logic [4:0]  comp_type_max;
    } t_cfg;

    // One ones'-complement addition with end-around carry.
    function automatic logic [15:0] add_word(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlvfc_cfg_regs.sv =====
// Configuration register file of the TLV frame checker.
`default_nettype none

module tlvfc_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tlvfc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [tlvfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output tlvfc_pkg::t_cfg                      o_cfg
);
    import tlvfc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_size    <= '0;
            r_cfg.frame_class   <= '0;
            r_cfg.prim_type_min <= 5'd0;
            r_cfg.prim_type_max <= 5'd31;
            r_cfg.comp_type_min <= 5'd0;
            r_cfg.comp_type_max <= 5'd31;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CHECK_SIZE:    r_cfg.check_size    <= i_cfg_wdata;
                CFG_FRAME_CLASS:   r_cfg.frame_class   <= i_cfg_wdata[1:0];
                CFG_PRIM_TYPE_MIN: r_cfg.prim_type_min <= i_cfg_wdata[4:0];
                CFG_PRIM_TYPE_MAX: r_cfg.prim_type_max <= i_cfg_wdata[4:0];
                CFG_COMP_TYPE_MIN: r_cfg.comp_type_min <= i_cfg_wdata[4:0];
                CFG_COMP_TYPE_MAX: r_cfg.comp_type_max <= i_cfg_wdata[4:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/tlv_frame_checker_unit.sv =====
// Top level of the TLV frame checker: byte-stream parser, checksum and result register.
`default_nettype none

// The unit takes one buffer byte per item on the slave stream, with tlast on the final
// byte of the buffer, and parses one frame from it: tag byte, length byte, an optional
// two- or four-byte big-endian length extension, the value bytes and a big-endian 16-bit
// ones'-complement checksum. Each value byte is forwarded as one item with tuser low, and
// tlast high on the final value byte; each buffer yields one status report with tuser high
// carrying the status, the tag fields and, for a completed frame, the decoded value and
// frame lengths. Bytes after a report up to the end of the buffer are dropped. Every byte
// is handled by the parser logic feeding a single result register, so the
// unit sustains one item per cycle; the slave side is ready whenever the result register
// is empty or being drained in the same cycle, which sets the only stall: a held result.
// Configuration writes take effect on the next cycle and are meant for idle periods.
module tlv_frame_checker_unit #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [tlvfc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [tlvfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Input byte stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  wire logic                            s_axis_tlast,  // buffer_last
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] value_byte, [9:8] status, [14:10] type_number, [15] is_composite,
    // [47:16] value_length, [80:48] frame_length, [87:81] zero
    output logic [87:0]                          m_axis_tdata,
    output logic                                 m_axis_tlast,  // value_last
    output logic                                 m_axis_tuser   // result_kind
);
    import tlvfc_pkg::*;

    localparam int LW = LENGTH_WIDTH;

    typedef enum logic [2:0] {
        PH_TAG, PH_LEN, PH_CHECK, PH_EXTRA, PH_VALUE, PH_SUM_HI, PH_SUM_LO
    } t_phase;

    t_cfg cfg;

    tlvfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Parser state.
    t_phase         r_phase, n_phase;
    logic [7:0]     r_tag, n_tag;
    logic [LW-1:0]  r_len, n_len;
    logic           r_ovf, n_ovf;
    logic [2:0]     r_left, n_left;
    logic [LW-1:0]  r_cnt, n_cnt;
    logic [15:0]    r_acc, n_acc;
    logic [7:0]     r_hi, n_hi;
    logic [15:0]    r_rsum, n_rsum;
    logic           r_skip, n_skip;
    logic [2:0]     r_hdr, n_hdr;

    // Result register.
    logic           r_ovld;
    logic           r_okind;
    logic [7:0]     r_obyte;
    logic           r_olast;
    logic [1:0]     r_ostat;
    logic [4:0]     r_otype;
    logic           r_ocomp;
    logic [31:0]    r_ovlen;
    logic [32:0]    r_oflen;

    logic           s_fire;
    logic [7:0]     b;
    logic           last;

    // Result of the current byte.
    logic           emit_val, emit_last;
    logic           rep_en, rep_len;
    logic [1:0]     rep_stat;

    // Effective state seen by the body logic; differs from the registers only on the
    // third byte, where the header decode and the first body byte are handled in the same cycle.
    logic           e_body;
    t_phase         e_phase;
    logic [LW-1:0]  e_len;
    logic [2:0]     e_left;
    logic           e_ovf;

    logic           tag_ok;
    logic [4:0]     num;
    logic [7:0]     lb;
    logic           cs_nonneg, cs_pos;
    logic [LW-1:0]  cs_cap, limit;
    logic [15:0]    acc_fin, calc;

    assign s_axis_tready = !r_ovld || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign last          = s_axis_tlast;

    assign cs_nonneg = !cfg.check_size[16];
    assign cs_pos    = cs_nonneg && (|cfg.check_size[15:0]);
    assign cs_cap    = LW'(cfg.check_size[15:0]);

    assign num = r_tag[4:0];
    assign lb  = r_len[7:0];

    always_comb begin
        n_phase = r_phase;
        n_tag   = r_tag;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_left  = r_left;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_hi    = r_hi;
        n_rsum  = r_rsum;
        n_skip  = r_skip;
        n_hdr   = r_hdr;

        emit_val  = 1'b0;
        emit_last = 1'b0;
        rep_en    = 1'b0;
        rep_len   = 1'b0;
        rep_stat  = ST_OK;

        e_body  = 1'b0;
        e_phase = r_phase;
        e_len   = r_len;
        e_left  = r_left;
        e_ovf   = r_ovf;
        tag_ok  = 1'b0;
        limit   = r_len;
        acc_fin = r_acc;
        calc    = '0;

        if (r_skip) begin
            if (last) begin
                n_skip  = 1'b0;
                n_phase = PH_TAG;
            end
        end else begin
            case (r_phase)
                PH_TAG: begin
                    n_tag  = b;
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    n_left = '0;
                    n_cnt  = '0;
                    n_acc  = '0;
                    n_hi   = '0;
                    n_rsum = '0;
                    n_hdr  = 3'd2;
                    if (last) begin
                        rep_en   = 1'b1;
                        rep_stat = ST_SHORT;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len = LW'(b);
                    if (last) begin
                        rep_en   = 1'b1;
                        rep_stat = ST_SHORT;
                    end else begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    tag_ok = (r_tag[7:6] == cfg.frame_class) &&
                             (r_tag[5] ? (num >= cfg.comp_type_min && num <= cfg.comp_type_max)
                                       : (num >= cfg.prim_type_min && num <= cfg.prim_type_max));
                    e_ovf = 1'b0;
                    if (tag_ok && lb[7]) begin
                        if (lb[6:0] == 7'd2 || lb[6:0] == 7'd4) begin
                            e_left  = lb[2:0];
                            n_hdr   = 3'd2 + lb[2:0];
                            e_len   = '0;
                            e_phase = PH_EXTRA;
                            e_body  = 1'b1;
                        end else begin
                            tag_ok = 1'b0;
                        end
                    end else if (tag_ok) begin
                        e_len   = LW'(lb[6:0]);
                        e_phase = (lb[6:0] == 7'd0) ? PH_SUM_HI : PH_VALUE;
                        e_body  = 1'b1;
                    end
                    if (!tag_ok) begin
                        rep_en   = 1'b1;
                        rep_stat = ST_MALFORMED;
                    end
                end
                PH_EXTRA, PH_VALUE, PH_SUM_HI, PH_SUM_LO: begin
                    e_body = 1'b1;
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase

            if (e_body) begin
                n_phase = e_phase;
                n_len   = e_len;
                n_left  = e_left;
                n_ovf   = e_ovf;
                limit   = (cs_pos && cs_cap < e_len) ? cs_cap : e_len;
                case (e_phase)
                    PH_EXTRA: begin
                        if (last) begin
                            rep_en   = 1'b1;
                            rep_stat = ST_SHORT;
                        end else begin
                            // Track length bits pushed past the top of the register.
                            n_ovf  = e_ovf | (|e_len[LW-1 -: 8]);
                            n_len  = {e_len[LW-9:0], b};
                            n_left = e_left - 3'd1;
                            if (n_left == 3'd0) begin
                                if (n_ovf) begin
                                    rep_en   = 1'b1;
                                    rep_stat = ST_MALFORMED;
                                end else begin
                                    n_phase = (n_len == '0) ? PH_SUM_HI : PH_VALUE;
                                end
                            end
                        end
                    end
                    PH_VALUE: begin
                        if (last) begin
                            rep_en   = 1'b1;
                            rep_stat = ST_SHORT;
                        end else begin
                            if (cs_nonneg && r_cnt < limit) begin
                                if (!r_cnt[0]) begin
                                    n_hi = b;
                                end else begin
                                    n_acc = add_word(r_acc, {r_hi, b});
                                end
                            end
                            n_cnt     = r_cnt + LW'(1);
                            emit_val  = 1'b1;
                            emit_last = (n_cnt == e_len);
                            if (n_cnt == e_len) begin
                                n_phase = PH_SUM_HI;
                            end
                        end
                    end
                    PH_SUM_HI: begin
                        if (last) begin
                            rep_en   = 1'b1;
                            rep_stat = ST_SHORT;
                        end else begin
                            n_rsum  = {b, 8'h00};
                            n_phase = PH_SUM_LO;
                        end
                    end
                    PH_SUM_LO: begin
                        n_rsum = {r_rsum[15:8], b};
                        // An odd final byte counts as the high half of a word.
                        acc_fin = limit[0] ? add_word(r_acc, {r_hi, 8'h00}) : r_acc;
                        if (cs_nonneg && e_len > LW'(1)) begin
                            calc = ~acc_fin;
                        end
                        rep_en   = 1'b1;
                        rep_len  = 1'b1;
                        rep_stat = (calc == n_rsum) ? ST_OK : ST_MISMATCH;
                    end
                    default: begin
                        n_phase = PH_TAG;
                    end
                endcase
            end

            if (rep_en) begin
                n_phase = PH_TAG;
                n_skip  = !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_tag   <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_left  <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_hi    <= '0;
            r_rsum  <= '0;
            r_skip  <= 1'b0;
            r_hdr   <= 3'd2;
            r_ovld  <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase <= n_phase;
                r_tag   <= n_tag;
                r_len   <= n_len;
                r_ovf   <= n_ovf;
                r_left  <= n_left;
                r_cnt   <= n_cnt;
                r_acc   <= n_acc;
                r_hi    <= n_hi;
                r_rsum  <= n_rsum;
                r_skip  <= n_skip;
                r_hdr   <= n_hdr;
                r_ovld  <= emit_val || rep_en;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
        // Result payload, loaded with each new result.
        if (s_fire && (emit_val || rep_en)) begin
            r_okind <= rep_en ? KIND_REPORT : KIND_VALUE;
            r_obyte <= rep_en ? 8'h00 : b;
            r_olast <= rep_en ? 1'b0 : emit_last;
            r_ostat <= rep_en ? rep_stat : ST_OK;
            r_otype <= rep_en ? n_tag[4:0] : 5'd0;
            r_ocomp <= rep_en ? n_tag[5] : 1'b0;
            r_ovlen <= (rep_en && rep_len) ? 32'(n_len) : 32'd0;
            r_oflen <= (rep_en && rep_len) ? (33'(n_hdr) + 33'(n_len) + 33'd2) : 33'd0;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {7'd0, r_oflen, r_ovlen, r_ocomp, r_otype, r_ostat, r_obyte};

    // A byte dropped while skipping to the buffer end must not create a result.
    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_skip) |=>
            (m_axis_tvalid == ($past(m_axis_tvalid) && !$past(m_axis_tready))))
        else $error("result produced for a skipped byte");

    // The final value byte always hands over to the checksum bytes.
    a_last_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_VALUE && m_axis_tlast) |-> (r_phase == PH_SUM_HI))
        else $error("final value byte not followed by checksum phase");

    // Every report returns the parser to the tag byte.
    a_report_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_REPORT) |-> (r_phase == PH_TAG))
        else $error("report issued without returning to tag phase");

    // The value byte counter stays below the length while value bytes are expected.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_cnt < r_len))
        else $error("value byte count reached length inside value phase");

endmodule

`default_nettype wire
